### rtl/mhpq_pkg.sv
package mhpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_LAST_DAT,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_UP,
        S_UP_CMP,
        S_RESP
    } state_t;

endpackage

### rtl/min_heap_priority_queue.sv
// Binary min-heap of signed 64-bit keys held in one single-port-read memory
// with a registered read. One operation per beat, one result beat each.
// Insert sifts the new key up one level at a time: read parent, compare, write.
// Remove minimum moves the last entry into the root and sifts it down by levels.
// Delete by key scans the memory one entry per cycle until it finds the key,
// then removes it as above; a key that is not found answers with a miss.
// Every step of a sift waits on the registered read of the memory.
// Refused operations and the unused opcode go straight to the result beat.
// No clearing pass is needed after reset.
module min_heap_priority_queue #(
    parameter int CAPACITY = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic signed [63:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic signed [63:0] min_key,
    output logic [11:0] count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 2;

    // heap storage
    logic [63:0] mem [CAPACITY];
    logic [63:0] rdata_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0] wr_data;

    mhpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [63:0]   val_reg, val_next;
    logic [63:0]   key_reg, key_next;
    logic [63:0]   cand_reg, cand_next;
    logic [AW-1:0] cidx_reg, cidx_next;
    logic          has_r_reg, has_r_next;
    logic          moved_reg, moved_next;
    logic [63:0]   root_reg;
    logic [1:0]    status_reg, status_next;

    logic [XW-1:0] left_idx;
    logic [XW-1:0] right_idx;
    logic [CW-1:0] last_idx;
    logic [AW-1:0] parent_idx;
    logic [63:0]   best;
    logic [AW-1:0] best_idx;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // root copy for the min output
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr == '0)
        begin
            root_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        key_reg      <= key_next;
        cand_reg     <= cand_next;
        cidx_reg     <= cidx_next;
        has_r_reg    <= has_r_next;
        moved_reg    <= moved_next;
        status_reg   <= status_next;
    end

    // index arithmetic
    assign left_idx   = {{(XW-AW-1){1'b0}}, pos_reg, 1'b1};
    assign right_idx  = left_idx + XW'(1);
    assign last_idx   = count_reg - CW'(1);
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);

    // smaller child
    always_comb
    begin
        best     = cand_reg;
        best_idx = cidx_reg;
        if (has_r_reg && $signed(rdata_reg) < $signed(cand_reg))
        begin
            best     = rdata_reg;
            best_idx = cidx_reg + AW'(1);
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        key_next      = key_reg;
        cand_next     = cand_reg;
        cidx_next     = cidx_reg;
        has_r_next    = has_r_reg;
        moved_next    = moved_reg;
        status_next   = status_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = val_reg;

        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next    = key;
                    status_next = mhpq_pkg::ST_DONE;
                    state_next  = mhpq_pkg::S_RESP;
                    unique case (opcode)
                        mhpq_pkg::OP_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = mhpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                pos_next   = count_reg[AW-1:0];
                                val_next   = key;
                                state_next = mhpq_pkg::S_UP;
                            end
                        end
                        mhpq_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = mhpq_pkg::ST_MISS;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = mhpq_pkg::S_SCAN;
                            end
                        end
                        mhpq_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = mhpq_pkg::ST_MISS;
                            end
                            else
                            begin
                                pos_next   = '0;
                                state_next = mhpq_pkg::S_LAST;
                            end
                        end
                        default:
                        begin
                            status_next = mhpq_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            // one read per cycle, compared against the key in the next cycle
            mhpq_pkg::S_SCAN:
            begin
                if (pend_reg && rdata_reg == key_reg)
                begin
                    pos_next   = pend_idx_reg;
                    state_next = mhpq_pkg::S_LAST;
                end
                else if (pend_reg && CW'(pend_idx_reg) == last_idx)
                begin
                    status_next = mhpq_pkg::ST_MISS;
                    state_next  = mhpq_pkg::S_RESP;
                end
                else if (scan_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_reg[AW-1:0];
                    scan_next     = scan_reg + CW'(1);
                end
            end

            // fetch last entry into the hole
            mhpq_pkg::S_LAST:
            begin
                count_next = last_idx;
                if (CW'(pos_reg) == last_idx)
                begin
                    state_next = mhpq_pkg::S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = last_idx[AW-1:0];
                    state_next = mhpq_pkg::S_LAST_DAT;
                end
            end

            mhpq_pkg::S_LAST_DAT:
            begin
                val_next   = rdata_reg;
                moved_next = 1'b0;
                state_next = mhpq_pkg::S_DN_L;
            end

            mhpq_pkg::S_DN_L:
            begin
                if (left_idx >= XW'(count_reg))
                begin
                    if (moved_reg)
                    begin
                        wr_en      = 1'b1;
                        state_next = mhpq_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = mhpq_pkg::S_UP;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left_idx[AW-1:0];
                    cidx_next  = left_idx[AW-1:0];
                    state_next = mhpq_pkg::S_DN_R;
                end
            end

            mhpq_pkg::S_DN_R:
            begin
                cand_next  = rdata_reg;
                has_r_next = right_idx < XW'(count_reg);
                if (right_idx < XW'(count_reg))
                begin
                    rd_en   = 1'b1;
                    rd_addr = right_idx[AW-1:0];
                end
                state_next = mhpq_pkg::S_DN_CMP;
            end

            mhpq_pkg::S_DN_CMP:
            begin
                if ($signed(best) < $signed(val_reg))
                begin
                    wr_en      = 1'b1;
                    wr_data    = best;
                    pos_next   = best_idx;
                    moved_next = 1'b1;
                    state_next = mhpq_pkg::S_DN_L;
                end
                else if (moved_reg)
                begin
                    wr_en      = 1'b1;
                    state_next = mhpq_pkg::S_RESP;
                end
                else
                begin
                    state_next = mhpq_pkg::S_UP;
                end
            end

            mhpq_pkg::S_UP:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = mhpq_pkg::S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent_idx;
                    state_next = mhpq_pkg::S_UP_CMP;
                end
            end

            mhpq_pkg::S_UP_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(val_reg) < $signed(rdata_reg))
                begin
                    wr_data    = rdata_reg;
                    pos_next   = parent_idx;
                    state_next = mhpq_pkg::S_UP;
                end
                else
                begin
                    state_next = mhpq_pkg::S_RESP;
                end
            end

            mhpq_pkg::S_RESP:
            begin
                if (!out_stall)
                begin
                    state_next = mhpq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // result beat
    assign in_stall  = state_reg != mhpq_pkg::S_IDLE;
    assign out_valid = state_reg == mhpq_pkg::S_RESP;
    assign status    = status_reg;
    assign min_key   = (count_reg == '0) ? 64'sd0 : $signed(root_reg);
    assign count     = 12'(count_reg);

endmodule
